>>> design/jasd_pkg.sv
// ----------------------------------------------------------------------------
// jasd_pkg: shared types and constants of the stream deframer
// Holds the parse phase encoding, frame kinds, marker bytes and the result
// record passed from the step logic to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jasd_pkg;

    localparam int LINE_MAX_DEF  = 510;
    localparam int AUDIO_MAX_DEF = 512;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;
    localparam int KIND_W = 2;

    localparam logic [BYTE_W-1:0] OPEN_BRACE = 8'h7B;
    localparam logic [BYTE_W-1:0] AUDIO_MARK = 8'hAA;
    localparam logic [BYTE_W-1:0] NEWLINE    = 8'h0A;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_TEXT   = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_LEN_HI = 3'd3,
        PH_DATA   = 3'd4
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_TEXT  = 2'd0,
        KIND_AUDIO = 2'd1,
        KIND_EOS   = 2'd2
    } kind_t;

    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic [LEN_W-1:0] position;
    } chunk_t;

    typedef struct packed {
        logic              emit;
        kind_t             kind;
        logic [BYTE_W-1:0] data;
        logic              data_valid;
        logic              frame_end;
    } result_t;

endpackage

`default_nettype wire

>>> design/jasd_step.sv
// ----------------------------------------------------------------------------
// jasd_step: per-byte phase decision of the stream deframer
// Computes the next parser state and the optional result for one received
// byte from the current state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jasd_step #(
    parameter int LINE_MAX  = jasd_pkg::LINE_MAX_DEF,
    parameter int AUDIO_MAX = jasd_pkg::AUDIO_MAX_DEF,
    parameter int LINE_W    = $clog2(LINE_MAX + 1)
) (
    input  wire logic [jasd_pkg::BYTE_W-1:0] rx_byte,
    input  wire jasd_pkg::phase_t            phase,
    input  wire logic [LINE_W-1:0]           line_count,
    input  wire jasd_pkg::chunk_t            chunk,
    output jasd_pkg::phase_t                 phase_next,
    output logic [LINE_W-1:0]                line_count_next,
    output jasd_pkg::chunk_t                 chunk_next,
    output jasd_pkg::result_t                result
);

    logic [jasd_pkg::LEN_W-1:0] pos_inc;
    logic [jasd_pkg::LEN_W-1:0] len_full;
    logic                       keep;
    logic                       last;

    assign pos_inc  = chunk.position + 1'b1;
    assign len_full = {rx_byte, chunk.length[jasd_pkg::BYTE_W-1:0]};
    assign keep     = chunk.position < jasd_pkg::LEN_W'(AUDIO_MAX);
    assign last     = pos_inc >= chunk.length;

    always_comb begin
        phase_next        = phase;
        line_count_next   = line_count;
        chunk_next        = chunk;
        result.emit       = 1'b0;
        result.kind       = jasd_pkg::KIND_TEXT;
        result.data       = '0;
        result.data_valid = 1'b0;
        result.frame_end  = 1'b0;
        unique case (phase)
            jasd_pkg::PH_TEXT: begin
                result.emit = 1'b1;
                if (rx_byte == jasd_pkg::NEWLINE || line_count >= LINE_W'(LINE_MAX)) begin
                    line_count_next  = '0;
                    phase_next       = jasd_pkg::PH_IDLE;
                    result.frame_end = 1'b1;
                end else begin
                    line_count_next   = line_count + 1'b1;
                    result.data       = rx_byte;
                    result.data_valid = 1'b1;
                end
            end
            jasd_pkg::PH_LEN_LO: begin
                chunk_next.length = {{(jasd_pkg::LEN_W-jasd_pkg::BYTE_W){1'b0}}, rx_byte};
                phase_next        = jasd_pkg::PH_LEN_HI;
            end
            jasd_pkg::PH_LEN_HI: begin
                chunk_next.length   = len_full;
                chunk_next.position = '0;
                if (len_full == '0) begin
                    phase_next       = jasd_pkg::PH_IDLE;
                    result.emit      = 1'b1;
                    result.kind      = jasd_pkg::KIND_EOS;
                    result.frame_end = 1'b1;
                end else begin
                    phase_next = jasd_pkg::PH_DATA;
                end
            end
            jasd_pkg::PH_DATA: begin
                chunk_next.position = pos_inc;
                if (last) begin
                    phase_next = jasd_pkg::PH_IDLE;
                end
                result.kind      = jasd_pkg::KIND_AUDIO;
                result.emit      = keep || last;
                result.frame_end = last;
                if (keep) begin
                    result.data       = rx_byte;
                    result.data_valid = 1'b1;
                end
            end
            default: begin
                phase_next = jasd_pkg::PH_IDLE;
                if (rx_byte == jasd_pkg::OPEN_BRACE) begin
                    line_count_next   = LINE_W'(1);
                    phase_next        = jasd_pkg::PH_TEXT;
                    result.emit       = 1'b1;
                    result.data       = rx_byte;
                    result.data_valid = 1'b1;
                end else if (rx_byte == jasd_pkg::AUDIO_MARK) begin
                    phase_next = jasd_pkg::PH_LEN_LO;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/json_audio_stream_deframer.sv
// ----------------------------------------------------------------------------
// json_audio_stream_deframer: splits a byte stream into text lines and audio
// Text lines open with a brace and close on a newline or at the length limit.
// Audio chunks open with a marker byte and a little-endian 16-bit length.
// ----------------------------------------------------------------------------
//  Channel   Direction  Ports                                        Content
//  s_        in         s_valid s_ready s_rx_byte                    link byte
//  m_        out        m_valid m_ready m_frame_kind m_data_byte     result
//                       m_data_valid m_frame_end
//
//  One byte is accepted per cycle while s_ready is high; its result, if any,
//  is written to the output register in the following cycle. Reset returns
//  the parser to idle with all counters clear.
//  A pending result stalls input only while m_ready is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module json_audio_stream_deframer #(
    parameter int LINE_MAX  = jasd_pkg::LINE_MAX_DEF,
    parameter int AUDIO_MAX = jasd_pkg::AUDIO_MAX_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [jasd_pkg::BYTE_W-1:0]       s_rx_byte,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [jasd_pkg::KIND_W-1:0]            m_frame_kind,
    output logic [jasd_pkg::BYTE_W-1:0]            m_data_byte,
    output logic                                   m_data_valid,
    output logic                                   m_frame_end
);

    localparam int LINE_W = $clog2(LINE_MAX + 1);

    jasd_pkg::phase_t  phase_reg, phase_next;
    logic [LINE_W-1:0] line_count_reg, line_count_next;
    jasd_pkg::chunk_t  chunk_reg, chunk_next;
    jasd_pkg::result_t step_result;
    jasd_pkg::result_t out_reg;
    logic              m_valid_reg, m_valid_next;
    logic              in_xfer;

    assign s_ready = !m_valid_reg || m_ready;
    assign in_xfer = s_valid && s_ready;

    jasd_step #(
        .LINE_MAX  (LINE_MAX),
        .AUDIO_MAX (AUDIO_MAX),
        .LINE_W    (LINE_W)
    ) u_step (
        .rx_byte         (s_rx_byte),
        .phase           (phase_reg),
        .line_count      (line_count_reg),
        .chunk           (chunk_reg),
        .phase_next      (phase_next),
        .line_count_next (line_count_next),
        .chunk_next      (chunk_next),
        .result          (step_result)
    );

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (in_xfer && step_result.emit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= jasd_pkg::PH_IDLE;
            line_count_reg <= '0;
            chunk_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (in_xfer) begin
                phase_reg      <= phase_next;
                line_count_reg <= line_count_next;
                chunk_reg      <= chunk_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer && step_result.emit) begin
            out_reg <= step_result;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_frame_kind = out_reg.kind;
    assign m_data_byte  = out_reg.data;
    assign m_data_valid = out_reg.data_valid;
    assign m_frame_end  = out_reg.frame_end;

    // A result without a data byte always closes a line, chunk or stream.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !out_reg.data_valid |-> out_reg.frame_end)
        else $error("data-less result without frame end");

    // End of stream never carries a data byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_reg.kind == jasd_pkg::KIND_EOS |-> !out_reg.data_valid)
        else $error("end of stream carries data");

    // The line counter stays within the limit and is clear outside a line.
    assert property (@(posedge aclk) disable iff (!aresetn)
        line_count_reg <= LINE_W'(LINE_MAX))
        else $error("line counter beyond limit");

    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != jasd_pkg::PH_TEXT |-> line_count_reg == '0)
        else $error("line counter set outside a text line");

endmodule

`default_nettype wire
